// File: rtl/snf_pkg.sv
// shared types and constants for the 3x3 smith normal form unit
// no dependencies
`default_nettype none
package snf_pkg;
  typedef logic [31:0] word_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOPIVOT = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;

  localparam logic [30:0] LIMIT_RESET = 31'd1000;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_SWAP,
    OP_DIV,
    OP_ROWELIM,
    OP_COLELIM,
    OP_MIXCHK,
    OP_ROWADD,
    OP_SIGNFIX
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] s;
    logic [1:0] idx;
    logic [1:0] jdx;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic div_busy;
    logic div_done;
    logic rem_nz;
    logic open;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/snf_div.sv
// iterative signed divider, one quotient bit a cycle, truncating
// depends on snf_pkg
`default_nettype none
module snf_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire snf_pkg::word_t num,
  input  wire snf_pkg::word_t den,
  output logic                busy,
  output logic                done,
  output snf_pkg::word_t      quot,
  output snf_pkg::word_t      rem
);
  import snf_pkg::*;

  logic [31:0] mag_n, mag_d, q, r;
  logic [5:0]  cnt;
  logic        neg_q, neg_r;
  logic [32:0] trial;

  assign trial = {r, q[31]} - {1'b0, mag_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd32;
        q     <= num[31] ? -num : num;
        r     <= 32'd0;
        mag_d <= den[31] ? -den : den;
        neg_q <= num[31] ^ den[31];
        neg_r <= num[31];
      end else if (busy) begin
        if (trial[32]) begin
          r <= {r[30:0], q[31]};
          q <= {q[30:0], 1'b0};
        end else begin
          r <= trial[31:0];
          q <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign mag_n = q;
  assign quot = neg_q ? -mag_n : mag_n;
  assign rem  = neg_r ? -r : r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("divider busy and done together");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");
`endif
endmodule
`default_nettype wire

// File: rtl/snf_datapath.sv
// matrix registers for D, L and R with pivot scan, swaps, eliminations, row additions and sign fix
// depends on snf_pkg and snf_div
`default_nettype none
module snf_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  wire snf_pkg::cmd_t  cmd,
  input  wire [30:0]          pivot_limit,
  input  wire snf_pkg::word_t ld [9],
  input  wire [1:0]           out_row,
  output snf_pkg::stat_t      stat,
  output snf_pkg::word_t      d_row [3],
  output snf_pkg::word_t      l_row [3],
  output snf_pkg::word_t      r_row [3]
);
  import snf_pkg::*;

  word_t d [3][3];
  word_t l [3][3];
  word_t r [3][3];
  logic [1:0] pr, pc;
  logic found;

  // pivot scan over the active trailing block
  logic [1:0] br, bc;
  logic       bf;
  logic [31:0] best, mag;
  always_comb begin
    best = {1'b0, pivot_limit};
    br = 2'd0;
    bc = 2'd0;
    bf = 1'b0;
    mag = 32'd0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mag = d[i][j][31] ? -d[i][j] : d[i][j];
        if (i >= int'(cmd.s) && j >= int'(cmd.s) && d[i][j] != 32'd0
            && ({1'b0, mag} < {1'b0, best}) && !(d[i][j] == 32'h8000_0000)) begin
          best = mag;
          br = 2'(i);
          bc = 2'(j);
          bf = 1'b1;
        end
      end
    end
  end

  // divider operand selection
  logic  dstart;
  word_t dnum, dq, drem;
  logic  dbusy, ddone;
  always_comb begin
    dstart = cmd.op == OP_DIV;
    dnum = d[cmd.idx][cmd.jdx];
  end

  snf_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(d[cmd.s][cmd.s]),
    .busy(dbusy), .done(ddone), .quot(dq), .rem(drem)
  );

  // eliminations run in the cycle the divider reports done, using its quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      found  <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              d[i][j] <= ld[i*3+j];
              l[i][j] <= (i == j) ? 32'd1 : 32'd0;
              r[i][j] <= (i == j) ? 32'd1 : 32'd0;
            end
          end
        end
        OP_SCAN: begin
          found <= bf;
          pr <= br;
          pc <= bc;
        end
        OP_SWAP: begin
          // row swap then column swap on the swapped rows
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              automatic int si = (i == int'(cmd.s)) ? int'(pr) :
                                 (i == int'(pr)) ? int'(cmd.s) : i;
              automatic int sj = (j == int'(cmd.s)) ? int'(pc) :
                                 (j == int'(pc)) ? int'(cmd.s) : j;
              d[i][j] <= d[si][sj];
              l[i][j] <= l[si][j];
              r[i][j] <= r[i][sj];
            end
          end
        end
        OP_DIV: ;
        OP_ROWELIM: begin
          for (int c = 0; c < 3; c++) begin
            d[cmd.idx][c] <= d[cmd.idx][c] - dq * d[cmd.s][c];
            l[cmd.idx][c] <= l[cmd.idx][c] - dq * l[cmd.s][c];
          end
        end
        OP_COLELIM: begin
          for (int rr = 0; rr < 3; rr++) begin
            d[rr][cmd.idx] <= d[rr][cmd.idx] - dq * d[rr][cmd.s];
            r[rr][cmd.idx] <= r[rr][cmd.idx] - dq * r[rr][cmd.s];
          end
        end
        OP_MIXCHK: ;
        OP_ROWADD: begin
          for (int c = 0; c < 3; c++) begin
            d[cmd.s][c] <= d[cmd.s][c] + d[cmd.idx][c];
            l[cmd.s][c] <= l[cmd.s][c] + l[cmd.idx][c];
          end
        end
        OP_SIGNFIX: begin
          for (int i = 0; i < 3; i++) begin
            if (d[i][i][31]) begin
              for (int c = 0; c < 3; c++) begin
                d[i][c] <= -d[i][c];
                l[i][c] <= -l[i][c];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.found = found;
    stat.div_busy = dbusy | dstart;
    stat.div_done = ddone;
    stat.rem_nz = drem != 32'd0;
    stat.open = 1'b0;
    for (int i = 1; i < 3; i++) begin
      if (i > int'(cmd.s) && (d[i][cmd.s] != 32'd0 || d[cmd.s][i] != 32'd0))
        stat.open = 1'b1;
    end
    for (int c = 0; c < 3; c++) begin
      d_row[c] = d[out_row][c];
      l_row[c] = l[out_row][c];
      r_row[c] = r[out_row][c];
    end
  end

`ifndef SYNTH
  a_swap_found: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SWAP |-> found) else $error("swap without pivot");
  a_elim_row: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_ROWELIM |-> cmd.idx > cmd.s) else $error("bad elimination row");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV |-> !dbusy) else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

// File: rtl/snf_ctrl.sv
// sequencer for the reduction passes and the three-row output
// depends on snf_pkg
`default_nettype none
module snf_ctrl #(
  parameter int MAX_PASSES = 255
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  wire snf_pkg::stat_t stat,
  output snf_pkg::cmd_t       cmd,
  output logic [1:0]          out_row,
  output logic [1:0]          status
);
  import snf_pkg::*;

  localparam int PW = $clog2(MAX_PASSES + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_PASS = 4'd1, S_SCAN = 4'd2,
    S_CHK = 4'd3, S_SWAP = 4'd4, S_RDIV = 4'd5, S_RWAIT = 4'd6,
    S_CDIV = 4'd7, S_CWAIT = 4'd8, S_OPEN = 4'd9, S_MDIV = 4'd10,
    S_MWAIT = 4'd11, S_NEXT = 4'd12, S_FIX = 4'd13, S_OUT = 4'd14;

  logic [3:0]    state;
  logic [PW-1:0] passes;
  logic [1:0]    asize;
  logic [1:0]    i, j;
  logic [1:0]    s;
  logic          mixed;

  assign s = 2'd3 - asize;
  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_comb begin
    cmd.op = OP_NONE;
    cmd.s = s;
    cmd.idx = i;
    cmd.jdx = j;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_SCAN: cmd.op = OP_SCAN;
      S_SWAP: cmd.op = OP_SWAP;
      S_RDIV: begin cmd.op = OP_DIV; cmd.jdx = s; end
      S_RWAIT: begin
        cmd.jdx = s;
        if (stat.div_done) cmd.op = OP_ROWELIM;
      end
      S_CDIV: begin cmd.op = OP_DIV; cmd.idx = s; cmd.jdx = i; end
      S_CWAIT: begin
        cmd.jdx = i;
        if (stat.div_done) cmd.op = OP_COLELIM;
      end
      S_MDIV: cmd.op = OP_DIV;
      S_NEXT: cmd.op = OP_ROWADD;
      S_FIX: cmd.op = OP_SIGNFIX;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      passes <= '0;
      asize <= 2'd3;
      i <= 2'd0;
      j <= 2'd0;
      mixed <= 1'b0;
      out_row <= 2'd0;
      status <= ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          asize <= 2'd3;
          passes <= '0;
          state <= S_PASS;
        end
        S_PASS: begin
          if (passes >= PW'(MAX_PASSES)) begin
            status <= ST_CAP;
            out_row <= 2'd0;
            state <= S_OUT;
          end else begin
            passes <= passes + PW'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: state <= S_CHK;
        S_CHK: begin
          if (!stat.found) begin
            status <= ST_NOPIVOT;
            out_row <= 2'd0;
            state <= S_OUT;
          end else state <= S_SWAP;
        end
        S_SWAP: begin i <= s + 2'd1; state <= S_RDIV; end
        S_RDIV: state <= S_RWAIT;
        S_RWAIT: if (stat.div_done) begin
          if (i == 2'd2) begin i <= s + 2'd1; state <= S_CDIV; end
          else begin i <= i + 2'd1; state <= S_RDIV; end
        end
        S_CDIV: state <= S_CWAIT;
        S_CWAIT: if (stat.div_done) begin
          if (i == 2'd2) state <= S_OPEN;
          else begin i <= i + 2'd1; state <= S_CDIV; end
        end
        S_OPEN: begin
          if (stat.open) state <= S_PASS;
          else begin
            i <= s + 2'd1;
            j <= s + 2'd1;
            mixed <= 1'b0;
            state <= S_MDIV;
          end
        end
        S_MDIV: state <= S_MWAIT;
        S_MWAIT: if (stat.div_done) begin
          if (stat.rem_nz) state <= S_NEXT;
          else if (j != 2'd2) begin j <= j + 2'd1; state <= S_MDIV; end
          else if (i != 2'd2) begin
            i <= i + 2'd1;
            j <= s + 2'd1;
            state <= S_MDIV;
          end else if (mixed) begin
            state <= S_PASS;
          end else begin
            // whole block divisible: shrink
            asize <= asize - 2'd1;
            state <= (asize == 2'd2) ? S_FIX : S_PASS;
          end
        end
        S_NEXT: begin
          // row added into the pivot row, go on with the next row
          mixed <= 1'b1;
          if (i != 2'd2) begin
            i <= i + 2'd1;
            j <= s + 2'd1;
            state <= S_MDIV;
          end else state <= S_PASS;
        end
        S_FIX: begin
          status <= ST_DONE;
          out_row <= 2'd0;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (out_row == 2'd2) begin
            state <= S_IDLE;
            out_row <= 2'd0;
          end else out_row <= out_row + 2'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_in_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_asize: assert property (@(posedge clk) disable iff (rst)
    asize >= 2'd1) else $error("active size underflow");
  a_passes: assert property (@(posedge clk) disable iff (rst)
    passes <= PW'(MAX_PASSES)) else $error("pass count beyond cap");
`endif
endmodule
`default_nettype wire

// File: rtl/smith_normal_form_3x3_unit.sv
// top level of the 3x3 smith normal form unit
// depends on snf_pkg, snf_ctrl, snf_datapath, snf_div
//
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | m00..m22
// out     | out | out_valid / out_ready | row_index, d/left/right_c*, status, last
// cfg     | in  | cfg_we                | cfg_data (pivot_limit)
//
// one matrix at a time; each division on the shared serial divider runs from start
// through a 32-bit quotient to done; a pass is setup (pass, scan, check, swap)
// plus up to 8 divisions, and ends after the check when no pivot is left
// a run takes up to MAX_PASSES passes
// three result transactions follow, one per row, held while out_ready is low
// reset restores pivot_limit to 1000; a new matrix is taken only when idle
`default_nettype none
module smith_normal_form_3x3_unit #(
  parameter int MAX_PASSES = 255
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [30:0]        cfg_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [1:0]        row_index,
  output logic signed [31:0] d_c0, d_c1, d_c2,
  output logic signed [31:0] left_c0, left_c1, left_c2,
  output logic signed [31:0] right_c0, right_c1, right_c2,
  output logic [1:0]        status,
  output logic              last
);
  import snf_pkg::*;

  logic [30:0] pivot_limit;
  cmd_t  cmd;
  stat_t stat;
  word_t ld [9];
  word_t dr [3], lr [3], rr [3];
  logic [1:0] out_row;

  always_ff @(posedge clk) begin
    if (rst) pivot_limit <= LIMIT_RESET;
    else if (cfg_we) pivot_limit <= cfg_data;
  end

  // sign-extend the input entries
  assign ld[0] = 32'(m00); assign ld[1] = 32'(m01); assign ld[2] = 32'(m02);
  assign ld[3] = 32'(m10); assign ld[4] = 32'(m11); assign ld[5] = 32'(m12);
  assign ld[6] = 32'(m20); assign ld[7] = 32'(m21); assign ld[8] = 32'(m22);

  snf_ctrl #(.MAX_PASSES(MAX_PASSES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
    .out_row(out_row), .status(status)
  );

  snf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .pivot_limit(pivot_limit), .ld(ld),
    .out_row(out_row), .stat(stat), .d_row(dr), .l_row(lr), .r_row(rr)
  );

  assign row_index = out_row;
  assign last = out_row == 2'd2;
  assign d_c0 = dr[0]; assign d_c1 = dr[1]; assign d_c2 = dr[2];
  assign left_c0 = lr[0]; assign left_c1 = lr[1]; assign left_c2 = lr[2];
  assign right_c0 = rr[0]; assign right_c1 = rr[1]; assign right_c2 = rr[2];
endmodule
`default_nettype wire

// File: verif/smith_normal_form_3x3_unit_tb.sv
// testbench for smith_normal_form_3x3_unit: random and directed 3x3 matrices,
// results checked against a built-in smith normal form predictor
// depends on snf_pkg and the rtl of smith_normal_form_3x3_unit
`default_nettype none
module smith_normal_form_3x3_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snf_pkg::*;

  localparam int PASS_CAP = 255;
  localparam int SETTLE_CYCLES = 40;

  // what the stimulus queue can hold
  typedef enum logic [1:0] {
    JOB_MATRIX,
    JOB_LIMIT,
    JOB_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t         kind;
    logic [8:0][15:0]  mat;
    logic [30:0]       limit;
  } job_t;

  // one expected result transaction: one row of D, L and R
  typedef struct {
    logic [1:0]  row;
    logic [31:0] d[3];
    logic [31:0] l[3];
    logic [31:0] r[3];
    logic [1:0]  st;
    logic        fin;
  } snf_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [8:0][15:0] cur_mat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] row_index;
  logic signed [31:0] d_c0, d_c1, d_c2;
  logic signed [31:0] left_c0, left_c1, left_c2;
  logic signed [31:0] right_c0, right_c1, right_c2;
  logic [1:0] status;
  logic last;

  job_t      job_q[$];
  snf_row_t  snf_rows_q[$];
  logic [30:0] limit_model = LIMIT_RESET;
  int        mismatches = 0;
  int        tail_start = 0;
  int        matrices_sent = 0;
  int        rows_seen = 0;
  bit        quiet_tail = 1'b0;

  smith_normal_form_3x3_unit i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(cur_mat[0]), .m01(cur_mat[1]), .m02(cur_mat[2]),
    .m10(cur_mat[3]), .m11(cur_mat[4]), .m12(cur_mat[5]),
    .m20(cur_mat[6]), .m21(cur_mat[7]), .m22(cur_mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index),
    .d_c0(d_c0), .d_c1(d_c1), .d_c2(d_c2),
    .left_c0(left_c0), .left_c1(left_c1), .left_c2(left_c2),
    .right_c0(right_c0), .right_c1(right_c1), .right_c2(right_c2),
    .status(status), .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // reduce one matrix and queue the three rows the block should send
  task automatic predict_snf(input logic [8:0][15:0] mat, input logic [30:0] lim);
    logic [31:0] dm[3][3];
    logic [31:0] lm[3][3];
    logic [31:0] rm[3][3];
    logic [31:0] k, t;
    logic [1:0] st;
    longint best, v, mag, p, q;
    int sz, passes, s, pr, pc;
    bit run, open, mixed;
    snf_row_t row;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        dm[r][c] = {{16{mat[r*3+c][15]}}, mat[r*3+c]};
        lm[r][c] = (r == c) ? 32'd1 : 32'd0;
        rm[r][c] = (r == c) ? 32'd1 : 32'd0;
      end
    end
    sz = 3;
    passes = 0;
    st = ST_DONE;
    run = 1'b1;
    while (run) begin
      if (passes >= PASS_CAP) begin
        st = ST_CAP;
        run = 1'b0;
      end else begin
        passes++;
        s = 3 - sz;
        // scan the active corner for the smallest eligible entry
        best = longint'(lim);
        pr = -1;
        pc = -1;
        for (int i = s; i < 3; i++) begin
          for (int j = s; j < 3; j++) begin
            v = longint'($signed(dm[i][j]));
            mag = (v < 0) ? -v : v;
            if (v != 0 && mag < best) begin
              best = mag;
              pr = i;
              pc = j;
            end
          end
        end
        if (s < 0 || s > 1 || pr < 0) begin
          st = ST_NOPIVOT;
          run = 1'b0;
        end else begin
          for (int c = 0; c < 3; c++) begin
            t = dm[pr][c]; dm[pr][c] = dm[s][c]; dm[s][c] = t;
            t = lm[pr][c]; lm[pr][c] = lm[s][c]; lm[s][c] = t;
          end
          for (int r = 0; r < 3; r++) begin
            t = dm[r][pc]; dm[r][pc] = dm[r][s]; dm[r][s] = t;
            t = rm[r][pc]; rm[r][pc] = rm[r][s]; rm[r][s] = t;
          end
          p = longint'($signed(dm[s][s]));
          // clear the pivot column, quotients truncated toward zero
          for (int i = s + 1; i < 3; i++) begin
            q = longint'($signed(dm[i][s])) / p;
            k = 32'(-q);
            for (int c = 0; c < 3; c++) begin
              dm[i][c] = dm[i][c] + k * dm[s][c];
              lm[i][c] = lm[i][c] + k * lm[s][c];
            end
          end
          // then the pivot row
          for (int i = s + 1; i < 3; i++) begin
            q = longint'($signed(dm[s][i])) / p;
            k = 32'(-q);
            for (int r = 0; r < 3; r++) begin
              dm[r][i] = dm[r][i] + k * dm[r][s];
              rm[r][i] = rm[r][i] + k * rm[r][s];
            end
          end
          open = 1'b0;
          for (int i = s + 1; i < 3; i++)
            if (dm[i][s] != 0 || dm[s][i] != 0) open = 1'b1;
          if (!open) begin
            // any row whose entries the pivot does not divide goes into the pivot row
            mixed = 1'b0;
            for (int i = s + 1; i < 3; i++) begin
              for (int j = s + 1; j < 3; j++) begin
                if ((longint'($signed(dm[i][j])) % p) != 0) begin
                  mixed = 1'b1;
                  for (int c = 0; c < 3; c++) begin
                    dm[s][c] = dm[s][c] + dm[i][c];
                    lm[s][c] = lm[s][c] + lm[i][c];
                  end
                  break;
                end
              end
            end
            if (!mixed) sz--;
            if (sz <= 1) run = 1'b0;
          end
        end
      end
    end
    // positive diagonal only on a finished run
    if (st == ST_DONE) begin
      for (int i = 0; i < 3; i++) begin
        if (dm[i][i][31]) begin
          for (int c = 0; c < 3; c++) begin
            dm[i][c] = -dm[i][c];
            lm[i][c] = -lm[i][c];
          end
        end
      end
    end
    for (int r = 0; r < 3; r++) begin
      row.row = 2'(r);
      row.d = dm[r];
      row.l = lm[r];
      row.r = rm[r];
      row.st = st;
      row.fin = (r == 2);
      snf_rows_q = {snf_rows_q, row};
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // driver: matrices, limit writes and drain points taken in queue order
  int send_gap = 0;
  int idle_count = 0;
  always @(posedge clk) begin
    logic next_valid;
    logic next_we;
    bit offering;
    next_valid = in_valid;
    next_we = 1'b0;
    if (rst) begin
      next_valid = 1'b0;
      idle_count = 0;
    end else begin
      idle_count = (snf_rows_q.size() == 0) ? idle_count + 1 : 0;
      offering = in_valid;
      if (in_valid && in_ready) begin
        // accepted transaction: predict against the limit in force now
        predict_snf(cur_mat, limit_model);
        offering = 1'b0;
        matrices_sent++;
        quiet_tail = (matrices_sent >= tail_start);
      end
      if (!offering) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (job_q.size() > 0) begin
          case (job_q[0].kind)
            JOB_MATRIX: begin
              if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 17);
              end else begin
                cur_mat <= job_q[0].mat;
                next_valid = 1'b1;
                void'(job_q.pop_front());
              end
            end
            JOB_LIMIT: begin
              // only write the limit once the block has gone quiet
              if (idle_count > SETTLE_CYCLES && !in_valid) begin
                cfg_data <= job_q[0].limit;
                next_we = 1'b1;
                limit_model = job_q[0].limit;
                void'(job_q.pop_front());
              end
            end
            default: begin
              if (snf_rows_q.size() == 0) void'(job_q.pop_front());
            end
          endcase
        end
      end
    end
    in_valid <= next_valid;
    cfg_we <= next_we;
  end

  // monitor: check each result row, drive out_ready with random stalls
  int hold_left = 0;
  int recv_gap = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    snf_row_t want;
    logic next_ready;
    if (rst) begin
      next_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rows_seen++;
        if (snf_rows_q.size() == 0) begin
          report_mismatch("unexpected row_index", 32'(row_index), '0);
        end else begin
          want = snf_rows_q.pop_front();
          if (row_index !== want.row) report_mismatch("row_index", 32'(row_index), 32'(want.row));
          if (d_c0 !== want.d[0]) report_mismatch("d_c0", d_c0, want.d[0]);
          if (d_c1 !== want.d[1]) report_mismatch("d_c1", d_c1, want.d[1]);
          if (d_c2 !== want.d[2]) report_mismatch("d_c2", d_c2, want.d[2]);
          if (left_c0 !== want.l[0]) report_mismatch("left_c0", left_c0, want.l[0]);
          if (left_c1 !== want.l[1]) report_mismatch("left_c1", left_c1, want.l[1]);
          if (left_c2 !== want.l[2]) report_mismatch("left_c2", left_c2, want.l[2]);
          if (right_c0 !== want.r[0]) report_mismatch("right_c0", right_c0, want.r[0]);
          if (right_c1 !== want.r[1]) report_mismatch("right_c1", right_c1, want.r[1]);
          if (right_c2 !== want.r[2]) report_mismatch("right_c2", right_c2, want.r[2]);
          if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
          if (last !== want.fin) report_mismatch("last", 32'(last), 32'(want.fin));
        end
      end
      // one long hold-off early on so the input side backs up
      if (!long_hold_done && rows_seen == 45) begin
        long_hold_done = 1'b1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        recv_gap = $urandom_range(1, 17);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready <= next_ready;
  end

  function automatic logic [8:0][15:0] random_matrix();
    logic [8:0][15:0] m;
    int flavor;
    int f;
    flavor = $urandom_range(0, 19);
    for (int e = 0; e < 9; e++) begin
      if (flavor < 10) m[e] = 16'($signed($urandom_range(0, 60)) - 30);
      else if (flavor < 14) m[e] = 16'($urandom);
      else if (flavor < 17) m[e] = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                   : 16'($signed($urandom_range(0, 400)) - 200);
      else m[e] = 16'($signed($urandom_range(0, 12)) - 6);
    end
    // rank-deficient: last row is a multiple of the first
    if (flavor >= 17) begin
      f = $signed($urandom_range(0, 6)) - 3;
      for (int c = 0; c < 3; c++) m[6+c] = 16'(f * $signed(m[c]));
    end
    return m;
  endfunction

  task automatic add_matrix(input logic [8:0][15:0] m);
    job_t j;
    j.kind = JOB_MATRIX;
    j.mat = m;
    j.limit = '0;
    job_q = {job_q, j};
  endtask

  task automatic add_job(input job_kind_t kind, input logic [30:0] lim);
    job_t j;
    j.kind = kind;
    j.mat = '0;
    j.limit = lim;
    job_q = {job_q, j};
  endtask

  function automatic logic [8:0][15:0] mat_of(input int a0, a1, a2, a3, a4, a5,
                                               a6, a7, a8);
    return {16'(a8), 16'(a7), 16'(a6), 16'(a5), 16'(a4), 16'(a3),
            16'(a2), 16'(a1), 16'(a0)};
  endfunction

  initial begin
    // directed part, reset limit of 1000
    add_matrix(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0));              // zero: no pivot
    add_matrix(mat_of(1, 0, 0, 0, 1, 0, 0, 0, 1));              // identity
    add_matrix(mat_of(2, 0, 0, 0, 3, 0, 0, 0, 5));              // coprime diagonal
    add_matrix(mat_of(-4, 0, 0, 0, -6, 0, 0, 0, 10));           // diagonal with negative entries
    add_matrix(mat_of(2, 4, 4, -6, 6, 12, 10, -4, -16));
    add_matrix(mat_of(1, 2, 3, 4, 5, 6, 7, 8, 9));              // singular
    add_matrix(mat_of(32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767, 32767));                    // all above limit
    add_matrix(mat_of(-32768, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
    add_matrix(mat_of(999, 0, 0, 0, 1000, 0, 0, 0, -999));      // limit boundary
    add_matrix(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 7));              // lone entry
    add_matrix(mat_of(0, 0, 0, 0, 5, 0, 0, 0, 0));              // rank one
    add_job(JOB_LIMIT, 31'h7FFF_FFFF);                          // top limit
    add_matrix(mat_of(-32768, 32767, -32768, 32767, -32768, 32767,
                      -32768, 32767, 1));
    add_matrix(mat_of(32767, -32768, 12345, -1, 32767, -32768, 21845, -21846, 3));
    add_matrix(mat_of(6, 10, 15, 0, 0, 0, 0, 0, 0));
    add_job(JOB_LIMIT, 31'd1);                                  // nothing eligible
    add_matrix(mat_of(1, 2, 3, -1, -2, -3, 5, 0, 1));
    add_matrix(mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_job(JOB_LIMIT, 31'd2);
    add_matrix(mat_of(1, 3, 5, 7, 9, 11, 13, 15, 17));
    add_matrix(mat_of(-1, 2, 0, 0, -1, 2, 2, 0, -1));
    // random part across several limits, with a drain point in the middle
    add_job(JOB_LIMIT, 31'h7FFF_FFFF);
    repeat (90) add_matrix(random_matrix());
    add_job(JOB_DRAIN, '0);
    repeat (20) add_matrix(random_matrix());
    add_job(JOB_LIMIT, 31'd9);
    repeat (40) add_matrix(random_matrix());
    add_job(JOB_LIMIT, 31'($urandom_range(1, 32'h7FFF_FFFE)));
    repeat (25) add_matrix(random_matrix());
    add_job(JOB_LIMIT, LIMIT_RESET);
    repeat (75) add_matrix(random_matrix());
    tail_start = 260;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (job_q.size() != 0 || in_valid || snf_rows_q.size() != 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && snf_rows_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well past the slowest legal run, every matrix at the pass cap
  initial begin
    #2000ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
